@@ rtl/core/cba_pkg.sv @@
// Shared types and constants for the chunk bitmap allocator.
// No dependencies; used by the interfaces and every core module.
`timescale 1ns / 1ps
package cba_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_RESIZE = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NO_RUN  = 2'd2;

  localparam int HEADER_BYTES  = 8;
  localparam int SEARCH_STRIDE = 8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] req_bytes;
    logic [7:0]  handle;
  } req_t;

  typedef struct packed {
    logic [7:0]  chunk_index;
    logic [1:0]  status;
    logic        moved;
    logic [15:0] old_bytes;
  } rsp_t;

endpackage

@@ rtl/core/cba_req_if.sv @@
// Valid/ready channel carrying one allocator request.
// Depends on cba_pkg.
`timescale 1ns / 1ps
interface cba_req_if;
  logic           valid;
  logic           ready;
  cba_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/cba_rsp_if.sv @@
// Valid/ready channel carrying one allocator response.
// Depends on cba_pkg.
`timescale 1ns / 1ps
interface cba_rsp_if;
  logic           valid;
  logic           ready;
  cba_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/chunk_bitmap_allocator.sv @@
// Chunk bitmap allocator top level: sequencer, bitmap and tag memories.
// Depends on cba_pkg, cba_req_if and cba_rsp_if.
//
//   channel   direction   payload                                    handshake
//   req       in          cmd, req_bytes, handle                     valid/ready
//   rsp       out         chunk_index, status, moved, old_bytes      valid/ready
//
// One request is processed at a time. After acceptance a request reads its
// size tag, then decides, then passes through the response state. The search
// tries run starts SEARCH_STRIDE apart, then the same at each further offset;
// each chunk visited passes through S_FETCH, where its bitmap address is
// presented, and S_CHECK, where its registered bit is checked, and each new
// start passes through S_NEXT. Runs are marked, and freed runs cleared, one
// chunk at a time. After reset a clearing pass writes zero to every bitmap
// entry, one per cycle, while req.ready stays low.
// The response sits in an output register; a new request is taken once the
// previous response has been handed off or while it is being taken.
`timescale 1ns / 1ps
module chunk_bitmap_allocator #(
  parameter int CHUNK_COUNT = 256,
  parameter int CHUNK_BYTES = 256
) (
  input  logic   clk,
  input  logic   rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);

  localparam int AW = $clog2(CHUNK_COUNT);
  // Count wide enough to hold CHUNK_COUNT itself and any chunk need when CHUNK_BYTES is at least 9.
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;

  // Division by CHUNK_BYTES is done as a multiply by a rounded-up reciprocal,
  // which is exact for every 17-bit dividend.
  localparam int          DIV_SH  = 17 + $clog2(CHUNK_BYTES);
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SH) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
  localparam logic [17:0] DIV_M   = DIV_M64[17:0];

  localparam cba_pkg::rsp_t RSP_BAD =
    '{chunk_index: 8'd0, status: cba_pkg::ST_BAD, moved: 1'b0, old_bytes: 16'd0};
  localparam cba_pkg::rsp_t RSP_NO_RUN =
    '{chunk_index: 8'd0, status: cba_pkg::ST_NO_RUN, moved: 1'b0, old_bytes: 16'd0};

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TAG    = 4'd2;  // tag read issued
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;  // scanning a candidate run
  localparam logic [3:0] S_MARK   = 4'd5;
  localparam logic [3:0] S_UNMARK = 4'd6;
  localparam logic [3:0] S_RESP   = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;  // advance search start
  localparam logic [3:0] S_FETCH  = 4'd9;  // bitmap read of pos issued

  logic [3:0]    state;
  cba_pkg::req_t cur;
  logic [CW-1:0] need, prev;
  logic [15:0]   tag_q;
  logic          grow;       // checking in-place growth rather than search
  logic [CW-1:0] start, off, pos, cnt;
  logic [CW-1:0] mstart, mlen, ustart, ulen;
  logic          mval, do_unmark, do_tag;
  logic [CW-1:0] tag_addr;
  cba_pkg::rsp_t res;
  logic          rsp_valid;

  // Bitmap memory: one write and one registered read per cycle.
  logic          bm [CHUNK_COUNT];
  logic          bm_rd;
  logic [AW-1:0] bm_raddr, bm_waddr;
  logic          bm_we, bm_wd;
  logic [15:0]   tags [CHUNK_COUNT];
  logic [15:0]   tag_rd;
  logic          tag_we;
  logic [AW-1:0] tag_waddr, tag_raddr;

  always_ff @(posedge clk) begin
    if (bm_we) bm[bm_waddr] <= bm_wd;
    bm_rd <= bm[bm_raddr];
    if (tag_we) tags[tag_waddr] <= cur.req_bytes;
    tag_rd <= tags[tag_raddr];
  end

  function automatic logic [CW-1:0] chunks_for(input logic [15:0] b);
    logic [16:0] s;
    logic [34:0] p;
    begin
      s = {1'b0, b} + 17'(cba_pkg::HEADER_BYTES);
      p = 35'(s) * 35'(DIV_M);
      chunks_for = CW'(p >> DIV_SH) + CW'(1);
    end
  endfunction

  wire [CW-1:0] n_cnt = CW'(CHUNK_COUNT);
  wire          accept = req.valid && req.ready;
  wire [CW-1:0] h_ext = CW'(cur.handle);
  wire [CW-1:0] tag_need = chunks_for(tag_rd);

  assign req.ready   = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = res;
  assign tag_raddr   = AW'(cur.handle);
  assign bm_raddr    = AW'(pos);

  // Write port control.
  always_comb begin
    bm_we = 1'b0;
    bm_waddr = AW'(cnt);
    bm_wd = 1'b0;
    tag_we = 1'b0;
    tag_waddr = AW'(tag_addr);
    if (state == S_CLEAR) begin
      bm_we = 1'b1;
    end else if (state == S_MARK && cnt < mlen && mstart + cnt < n_cnt) begin
      bm_we = 1'b1;
      bm_waddr = AW'(mstart + cnt);
      bm_wd = mval;
    end else if (state == S_UNMARK && cnt < ulen && ustart + cnt < n_cnt) begin
      bm_we = 1'b1;
      bm_waddr = AW'(ustart + cnt);
    end
    if (state == S_RESP && do_tag) tag_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == n_cnt - 1'b1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cur <= req.payload;
            need <= chunks_for(req.payload.req_bytes);
            state <= S_TAG;
          end
        end
        S_TAG: state <= S_DECIDE;
        S_DECIDE: begin
          tag_q <= tag_rd;
          prev <= tag_need;
          do_unmark <= 1'b0;
          cnt <= '0;
          case (cur.cmd)
            cba_pkg::CMD_ALLOC: begin
              do_tag <= 1'b0;
              if (cur.req_bytes == '0 || need >= n_cnt) begin
                res <= RSP_BAD;
                state <= S_RESP;
              end else begin
                res <= '0;
                grow <= 1'b0; start <= '0; off <= '0; pos <= '0;
                state <= S_FETCH;
              end
            end
            cba_pkg::CMD_RESIZE: begin
              if (h_ext >= n_cnt || need >= n_cnt) begin
                do_tag <= 1'b0;
                res <= RSP_BAD;
                state <= S_RESP;
              end else if (tag_need >= need) begin
                res <= '{chunk_index: cur.handle, status: cba_pkg::ST_OK,
                         moved: 1'b0, old_bytes: tag_rd};
                do_tag <= 1'b1; tag_addr <= h_ext;
                ustart <= h_ext + need;
                ulen <= tag_need - need;
                state <= S_UNMARK;
              end else if (need > n_cnt - h_ext) begin
                do_tag <= 1'b0;
                res <= '0;
                grow <= 1'b0; start <= '0; off <= '0; pos <= '0;
                state <= S_FETCH;
              end else begin
                do_tag <= 1'b0;
                res <= '0;
                grow <= 1'b1;
                start <= h_ext + tag_need;
                pos <= h_ext + tag_need;
                state <= S_FETCH;
              end
            end
            cba_pkg::CMD_FREE: begin
              do_tag <= 1'b0;
              if (h_ext >= n_cnt) begin
                res <= RSP_BAD;
                state <= S_RESP;
              end else begin
                res <= '{chunk_index: cur.handle, status: cba_pkg::ST_OK,
                         moved: 1'b0, old_bytes: 16'd0};
                ustart <= h_ext;
                ulen <= tag_need;
                state <= S_UNMARK;
              end
            end
            default: begin
              do_tag <= 1'b0;
              res <= RSP_BAD;
              state <= S_RESP;
            end
          endcase
        end
        // The address pos is presented here; its bit is in bm_rd next cycle.
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          if (!grow && start + need > n_cnt) begin
            state <= S_NEXT;
          end else if (bm_rd) begin
            if (grow) begin
              grow <= 1'b0; start <= '0; off <= '0; pos <= '0;
              state <= S_FETCH;
            end else begin
              state <= S_NEXT;
            end
          end else if (pos + 1'b1 == start + (grow ? need - prev : need)) begin
            // Whole run free.
            mval <= 1'b1;
            mlen <= need;
            do_tag <= 1'b1;
            res.old_bytes <= (cur.cmd == cba_pkg::CMD_RESIZE) ? tag_q : '0;
            if (grow) begin
              mstart <= h_ext;
              tag_addr <= h_ext;
              res.chunk_index <= cur.handle;
            end else begin
              mstart <= start;
              tag_addr <= start;
              res.chunk_index <= start[7:0];
              if (cur.cmd == cba_pkg::CMD_RESIZE) begin
                res.moved <= 1'b1;
                do_unmark <= 1'b1;
                ustart <= h_ext;
                ulen <= prev;
              end
            end
            state <= S_MARK;
          end else begin
            pos <= pos + 1'b1;
            state <= S_FETCH;
          end
        end
        S_NEXT: begin
          if (start + CW'(cba_pkg::SEARCH_STRIDE) < n_cnt) begin
            start <= start + CW'(cba_pkg::SEARCH_STRIDE);
            pos <= start + CW'(cba_pkg::SEARCH_STRIDE);
            state <= S_FETCH;
          end else if (off + 1'b1 < CW'(cba_pkg::SEARCH_STRIDE)
                       && off + 1'b1 < n_cnt) begin
            off <= off + 1'b1;
            start <= off + 1'b1;
            pos <= off + 1'b1;
            state <= S_FETCH;
          end else begin
            res <= RSP_NO_RUN;
            do_tag <= 1'b0;
            state <= S_RESP;
          end
        end
        S_MARK: begin
          if (cnt + 1'b1 >= mlen) begin
            cnt <= '0;
            state <= do_unmark ? S_UNMARK : S_RESP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_UNMARK: begin
          if (cnt + 1'b1 >= ulen || ulen == '0) begin
            cnt <= '0;
            state <= S_RESP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RESP: begin
          if (!rsp_valid) begin
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_rsp_after_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !rsp_valid) |=> rsp_valid) else $error("lost response");
  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && res.moved) |-> res.status == cba_pkg::ST_OK)
    else $error("moved with error");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && res.status != cba_pkg::ST_OK) |-> res.chunk_index == '0)
    else $error("error index nonzero");
`endif

endmodule
